[design/assert_macros.svh]
// Assertion macros shared by the packetiser RTL.
// Synthesis builds see empty bodies; simulation builds get concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HRF_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication check failed");
`define HRF_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define HRF_ASSERT_IMP(name, clk, rst_n, pre, post)
`define HRF_ASSERT_NXT(name, clk, rst_n, pre, post)
`endif
`endif

[design/hrf_pkg.sv]
// Types and constants of the H.264 RTP FU-A packetiser.
// No dependencies; used by every module of the block.
`default_nettype none
package hrf_pkg;

    localparam logic [10:0] PAYLOAD_FLOOR = 11'd1100;
    localparam logic [10:0] PAYLOAD_CEIL  = 11'd1400;
    localparam logic [4:0]  FU_A_TYPE     = 5'd28;
    localparam logic [1:0]  RTP_VERSION   = 2'd2;
    localparam logic [1:0]  PREFIX_SINGLE = 2'd1;
    localparam logic [1:0]  PREFIX_FU_A   = 2'd2;

    localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd0;
    localparam logic [1:0] REG_TS_STEP      = 2'd1;
    localparam logic [1:0] REG_RTP_PT       = 2'd2;
    localparam logic [1:0] REG_SSRC_VALUE   = 2'd3;

    localparam logic [10:0] RST_MAX_PAYLOAD  = 11'd1400;
    localparam logic [16:0] RST_TS_STEP      = 17'd3600;
    localparam logic [6:0]  RST_RTP_PT       = 7'd96;
    localparam logic [31:0] RST_SSRC_VALUE   = 32'd44;

    typedef struct packed {
        logic [7:0]  nal_header_byte;
        logic [15:0] nal_length;
    } in_item_t;

    typedef struct packed {
        logic [31:0] rtp_word0;
        logic [31:0] rtp_timestamp;
        logic [31:0] rtp_ssrc;
        logic [15:0] prefix_bytes;
        logic [1:0]  prefix_len;
        logic [15:0] payload_offset;
        logic [10:0] payload_length;
        logic        last_packet;
        logic        error_flag;
    } out_item_t;

    typedef struct packed {
        logic [10:0] payload_size;   // max_payload saturated to the legal range
        logic [16:0] ts_step;
        logic [6:0]  rtp_pt;
        logic [31:0] ssrc_value;
    } cfg_t;

    typedef struct packed {
        logic [16:0] end_offset;
        logic        is_last;
        logic [15:0] offset;
        logic [10:0] length;
    } frag_res_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

[design/hrf_cfg_regs.sv]
// Configuration register file of the packetiser, with payload size saturation.
// Depends on hrf_pkg.
`default_nettype none
module hrf_cfg_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    output hrf_pkg::cfg_t     cfg
);

    logic [10:0] max_payload_reg;
    logic [16:0] ts_step_reg;
    logic [6:0]  rtp_pt_reg;
    logic [31:0] ssrc_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg  <= hrf_pkg::RST_MAX_PAYLOAD;
            ts_step_reg      <= hrf_pkg::RST_TS_STEP;
            rtp_pt_reg       <= hrf_pkg::RST_RTP_PT;
            ssrc_value_reg   <= hrf_pkg::RST_SSRC_VALUE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hrf_pkg::REG_MAX_PAYLOAD:  max_payload_reg  <= cfg_data[10:0];
                hrf_pkg::REG_TS_STEP:      ts_step_reg      <= cfg_data[16:0];
                hrf_pkg::REG_RTP_PT:       rtp_pt_reg       <= cfg_data[6:0];
                hrf_pkg::REG_SSRC_VALUE:   ssrc_value_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (max_payload_reg < hrf_pkg::PAYLOAD_FLOOR)
            cfg.payload_size = hrf_pkg::PAYLOAD_FLOOR;
        else if (max_payload_reg > hrf_pkg::PAYLOAD_CEIL)
            cfg.payload_size = hrf_pkg::PAYLOAD_CEIL;
        else
            cfg.payload_size = max_payload_reg;
        cfg.ts_step      = ts_step_reg;
        cfg.rtp_pt       = rtp_pt_reg;
        cfg.ssrc_value   = ssrc_value_reg;
    end

endmodule
`default_nettype wire

[design/hrf_frag_unit.sv]
// Shared fragment arithmetic: one add-and-compare and two subtracts per packet.
// Depends on hrf_pkg.
`default_nettype none
module hrf_frag_unit (
    input  wire logic [16:0]   base,
    input  wire logic [10:0]   payload_size,
    input  wire logic [15:0]   nal_length,
    input  wire logic          first,
    output hrf_pkg::frag_res_t res
);

    logic [16:0] end_sum;
    logic [15:0] offset;
    logic [15:0] remain;

    always_comb
    begin
        end_sum = base + {6'd0, payload_size};
        // The first packet skips the header byte, which is never copied.
        offset  = first ? 16'd1 : base[15:0];
        remain  = nal_length - offset;

        res.end_offset = end_sum;
        res.is_last    = (end_sum >= {1'b0, nal_length});
        res.offset     = offset;
        if (res.is_last)
            res.length = remain[10:0];
        else if (first)
            res.length = payload_size - 11'd1;
        else
            res.length = payload_size;
    end

endmodule
`default_nettype wire

[design/h264_rtp_fua_packetizer_top.sv]
// Start: after the NAL transfer, state_reg enters ST_EMIT and the first descriptor
// is then registered in out_data_reg. Throughput: one descriptor per cycle while
// the output is taken; in_ready stays low until the last packet of a NAL is loaded,
// as the shared fragment add/compare unit steps once per packet.
// Reset: rst_n clears sequence number, timestamp and handshakes at once; the
// configuration registers return to their defaults. No clearing pass.
`default_nettype none
`include "assert_macros.svh"
module h264_rtp_fua_packetizer_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire hrf_pkg::in_item_t in_data,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      hrf_pkg::out_item_t out_data,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_data
);

    hrf_pkg::cfg_t      cfg;
    hrf_pkg::frag_res_t frag;
    hrf_pkg::state_t    state_reg, state_next;
    hrf_pkg::out_item_t out_data_reg, out_data_next;

    logic [7:0]  hdr_reg;
    logic [15:0] len_reg;
    logic [16:0] base_reg, base_next;
    logic        first_reg, first_next;
    logic [15:0] seq_reg, seq_next;
    logic [31:0] ts_reg, ts_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept;
    logic        load;
    logic        is_error;
    logic        single;
    logic        done;

    hrf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hrf_frag_unit u_frag (
        .base         (base_reg),
        .payload_size (cfg.payload_size),
        .nal_length   (len_reg),
        .first        (first_reg),
        .res          (frag)
    );

    assign is_error = (len_reg == 16'd0);
    assign single   = first_reg && frag.is_last;
    assign done     = is_error || frag.is_last;

    // Sequencer outputs.
    always_comb
    begin
        in_ready = (state_reg == hrf_pkg::ST_IDLE);
        load     = (state_reg == hrf_pkg::ST_EMIT) && (!out_valid_reg || out_ready);
        accept   = in_valid && in_ready;
    end

    // Sequencer next state.
    always_comb
    begin
        case (state_reg)
            hrf_pkg::ST_IDLE:
                state_next = in_valid ? hrf_pkg::ST_EMIT : hrf_pkg::ST_IDLE;
            hrf_pkg::ST_EMIT:
                state_next = (load && done) ? hrf_pkg::ST_IDLE : hrf_pkg::ST_EMIT;
            default:
                state_next = hrf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        base_next      = base_reg;
        first_next     = first_reg;
        seq_next       = seq_reg;
        ts_next        = ts_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        if (accept)
        begin
            ts_next    = ts_reg + {15'd0, cfg.ts_step};
            base_next  = 17'd0;
            first_next = 1'b1;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
            if (is_error)
            begin
                out_data_next             = '0;
                out_data_next.last_packet = 1'b1;
                out_data_next.error_flag  = 1'b1;
            end
            else
            begin
                seq_next   = seq_reg + 16'd1;
                base_next  = frag.end_offset;
                first_next = 1'b0;
                out_data_next.rtp_word0 = {hrf_pkg::RTP_VERSION, 6'd0,
                                           frag.is_last && !single,
                                           cfg.rtp_pt, seq_reg + 16'd1};
                out_data_next.rtp_timestamp = ts_reg;
                out_data_next.rtp_ssrc      = cfg.ssrc_value;
                if (single)
                begin
                    out_data_next.prefix_bytes = {hdr_reg, 8'd0};
                    out_data_next.prefix_len   = hrf_pkg::PREFIX_SINGLE;
                end
                else
                begin
                    out_data_next.prefix_bytes = {hdr_reg[7:5], hrf_pkg::FU_A_TYPE,
                                                  first_reg, frag.is_last, 1'b0,
                                                  hdr_reg[4:0]};
                    out_data_next.prefix_len   = hrf_pkg::PREFIX_FU_A;
                end
                out_data_next.payload_offset = frag.offset;
                out_data_next.payload_length = frag.length;
                out_data_next.last_packet    = frag.is_last;
                out_data_next.error_flag     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hrf_pkg::ST_IDLE;
            seq_reg       <= 16'd0;
            ts_reg        <= 32'd0;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b1;
            base_reg      <= 17'd0;
        end
        else
        begin
            state_reg     <= state_next;
            seq_reg       <= seq_next;
            ts_reg        <= ts_next;
            out_valid_reg <= out_valid_next;
            first_reg     <= first_next;
            base_reg      <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hdr_reg <= in_data.nal_header_byte;
            len_reg <= in_data.nal_length;
        end
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `HRF_ASSERT_IMP(a_error_shape, clk, rst_n, out_valid && out_data.error_flag,
        out_data.last_packet && (out_data.prefix_len == 2'd0))
    `HRF_ASSERT_IMP(a_len_bound, clk, rst_n, out_valid && !out_data.error_flag,
        out_data.payload_length <= hrf_pkg::PAYLOAD_CEIL)
    `HRF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `HRF_ASSERT_NXT(a_seq_steps, clk, rst_n, load && !is_error,
        seq_reg == $past(seq_reg) + 16'd1)

endmodule
`default_nettype wire

[bench/fua_descriptor_checker.sv]
`timescale 1ns / 100ps
// Watches the NAL, descriptor and register ports of the FU-A packetiser and predicts
// every packet descriptor. Depends on hrf_pkg for the payload structs and constants.
module fua_descriptor_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  hrf_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  hrf_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 mismatches,
    output int                 descriptors_due
);

    // Shadow copy of the registers and of the packetiser state.
    logic [10:0] max_payload_reg;
    logic [16:0] ts_step_reg;
    logic [6:0]  pt_reg;
    logic [31:0] ssrc_reg;
    logic [15:0] seq_num;
    logic [31:0] nal_ts;

    hrf_pkg::out_item_t pending_descriptors[$];
    hrf_pkg::out_item_t oldest;

    initial begin
        mismatches      = 0;
        descriptors_due = 0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t fua checker: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v, input logic [15:0] seq);
        if (want_v !== got_v)
            report_mismatch($sformatf("%s of descriptor seq %0d: expected 0x%0h, got 0x%0h",
                                      name, seq, want_v, got_v));
    endtask

    task automatic compare_descriptor(input hrf_pkg::out_item_t want,
                                      input hrf_pkg::out_item_t got);
        logic [15:0] seq;
        seq = want.rtp_word0[15:0];
        check_field("rtp_word0", want.rtp_word0, got.rtp_word0, seq);
        check_field("rtp_timestamp", want.rtp_timestamp, got.rtp_timestamp, seq);
        check_field("rtp_ssrc", want.rtp_ssrc, got.rtp_ssrc, seq);
        check_field("prefix_bytes", 32'(want.prefix_bytes), 32'(got.prefix_bytes), seq);
        check_field("prefix_len", 32'(want.prefix_len), 32'(got.prefix_len), seq);
        check_field("payload_offset", 32'(want.payload_offset), 32'(got.payload_offset),
                    seq);
        check_field("payload_length", 32'(want.payload_length), 32'(got.payload_length),
                    seq);
        check_field("last_packet", 32'(want.last_packet), 32'(got.last_packet), seq);
        check_field("error_flag", 32'(want.error_flag), 32'(got.error_flag), seq);
    endtask

    task automatic add_descriptor(input logic marker, input logic [15:0] prefix,
                                  input logic [1:0] plen, input int off, input int len,
                                  input logic last);
        hrf_pkg::out_item_t d;
        seq_num = seq_num + 16'd1;
        d = '0;
        d.rtp_word0      = {hrf_pkg::RTP_VERSION, 6'b0, marker, pt_reg, seq_num};
        d.rtp_timestamp  = nal_ts;
        d.rtp_ssrc       = ssrc_reg;
        d.prefix_bytes   = prefix;
        d.prefix_len     = plen;
        d.payload_offset = off[15:0];
        d.payload_length = len[10:0];
        d.last_packet    = last;
        d.error_flag     = 1'b0;
        pending_descriptors.push_back(d);
    endtask

    task automatic packetize_nal(input hrf_pkg::in_item_t nal);
        int        len;
        int        frag_size;
        int        frag_count;
        int        off;
        int        flen;
        int        k;
        logic      first;
        logic      last;
        logic [7:0] fu_ind;
        logic [7:0] fu_hdr;
        hrf_pkg::out_item_t err;
        nal_ts = nal_ts + 32'(ts_step_reg);
        len = int'(nal.nal_length);
        if (len == 0) begin
            // An empty NAL yields a bare error descriptor and no sequence number.
            err = '0;
            err.last_packet = 1'b1;
            err.error_flag  = 1'b1;
            pending_descriptors.push_back(err);
        end
        else begin
            frag_size = int'(max_payload_reg);
            if (frag_size < int'(hrf_pkg::PAYLOAD_FLOOR))
                frag_size = int'(hrf_pkg::PAYLOAD_FLOOR);
            if (frag_size > int'(hrf_pkg::PAYLOAD_CEIL))
                frag_size = int'(hrf_pkg::PAYLOAD_CEIL);
            if (len <= frag_size) begin
                add_descriptor(1'b0, {nal.nal_header_byte, 8'h00}, hrf_pkg::PREFIX_SINGLE,
                               1, len - 1, 1'b1);
            end
            else begin
                frag_count = (len + frag_size - 1) / frag_size;
                fu_ind = {nal.nal_header_byte[7:5], hrf_pkg::FU_A_TYPE};
                for (k = 0; k < frag_count; k++) begin
                    first  = (k == 0);
                    last   = (k == frag_count - 1);
                    off    = first ? 1 : k * frag_size;
                    flen   = last ? len - off : (first ? frag_size - 1 : frag_size);
                    fu_hdr = {first, last, 1'b0, nal.nal_header_byte[4:0]};
                    add_descriptor(last, {fu_ind, fu_hdr}, hrf_pkg::PREFIX_FU_A, off, flen,
                                   last);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_payload_reg = hrf_pkg::RST_MAX_PAYLOAD;
            ts_step_reg     = hrf_pkg::RST_TS_STEP;
            pt_reg          = hrf_pkg::RST_RTP_PT;
            ssrc_reg        = hrf_pkg::RST_SSRC_VALUE;
            seq_num         = '0;
            nal_ts          = '0;
            pending_descriptors.delete();
            descriptors_due = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    hrf_pkg::REG_MAX_PAYLOAD:  max_payload_reg = cfg_data[10:0];
                    hrf_pkg::REG_TS_STEP:      ts_step_reg     = cfg_data[16:0];
                    hrf_pkg::REG_RTP_PT:       pt_reg          = cfg_data[6:0];
                    hrf_pkg::REG_SSRC_VALUE:   ssrc_reg        = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                packetize_nal(in_data);
            if (out_valid && out_ready) begin
                if (pending_descriptors.size() == 0) begin
                    report_mismatch("descriptor transfer with none expected");
                end
                else begin
                    oldest = pending_descriptors.pop_front();
                    compare_descriptor(oldest, out_data);
                end
            end
            descriptors_due = pending_descriptors.size();
        end
    end

endmodule

[bench/tb_h264_rtp_fua_packetizer_top.sv]
`timescale 1ns / 100ps
// Stimulus and verdict for the H.264 RTP FU-A packetiser: NALs, register settings and
// receiver stalls. Depends on hrf_pkg, the block and fua_descriptor_checker.
module tb_h264_rtp_fua_packetizer_top;

    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 70;
    localparam int RANDOM_NALS  = 18;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    hrf_pkg::in_item_t  in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    hrf_pkg::out_item_t out_data;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int mismatches;
    int descriptors_due;
    int idle_cycles = 0;
    int rx_tick     = 0;
    int burst_left  = 0;
    int frag_size   = 1400;

    h264_rtp_fua_packetizer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fua_descriptor_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .descriptors_due (descriptors_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: the stall pattern rotates between always ready,
    // mostly ready, a fixed three-in-seven stall and a coin toss.
    always @(negedge clk)
    begin
        case ((rx_tick / 97) % 4)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ((rx_tick % 7) >= 3);
            default: out_ready <= 1'($urandom_range(0, 1));
        endcase
        rx_tick++;
    end

    // Watchdog: a run with no transfer for too long has hung.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_h264_rtp_fua_packetizer_top: done, errors");
                $finish;
            end
        end
    end

    // Offers one NAL and returns at the edge of its transfer. Between bursts the
    // valid line may drop for a random gap.
    task automatic send_nal(input logic [7:0] hdr, input int len);
        hrf_pkg::in_item_t item;
        item.nal_header_byte = hdr;
        item.nal_length      = len[15:0];
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Holds the sender off until every predicted descriptor has been seen.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (descriptors_due != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    // Registers change only with the block idle. With dirty set, the unused upper
    // bits of the narrow registers carry junk that the block must ignore.
    task automatic configure(input logic [10:0] mp, input logic [16:0] step,
                             input logic [6:0] pt, input logic [31:0] ssrc, input bit dirty);
        logic [31:0] junk;
        junk = dirty ? $urandom() : 32'd0;
        drain();
        write_reg(hrf_pkg::REG_MAX_PAYLOAD, {junk[31:11], mp});
        write_reg(hrf_pkg::REG_TS_STEP, {junk[31:17], step});
        write_reg(hrf_pkg::REG_RTP_PT, {junk[31:7], pt});
        write_reg(hrf_pkg::REG_SSRC_VALUE, ssrc);
        cfg_we <= 1'b0;
        frag_size = int'(mp);
        if (frag_size < int'(hrf_pkg::PAYLOAD_FLOOR))
            frag_size = int'(hrf_pkg::PAYLOAD_FLOOR);
        if (frag_size > int'(hrf_pkg::PAYLOAD_CEIL))
            frag_size = int'(hrf_pkg::PAYLOAD_CEIL);
    endtask

    task automatic configure_random();
        logic [10:0] mp;
        logic [16:0] step;
        case ($urandom_range(0, 3))
            0:       mp = hrf_pkg::PAYLOAD_FLOOR;
            1:       mp = hrf_pkg::PAYLOAD_CEIL;
            2:       mp = 11'($urandom_range(1100, 1400));
            default: mp = 11'($urandom_range(0, 2047));
        endcase
        case ($urandom_range(0, 3))
            0:       step = 17'd1;
            1:       step = 17'd90000;
            2:       step = 17'($urandom_range(1, 90000));
            default: step = 17'($urandom_range(0, 131071));
        endcase
        configure(mp, step, 7'($urandom_range(0, 127)), $urandom(), 1'($urandom_range(0, 1)));
    endtask

    // Lengths weighted towards the single/fragment boundaries and multiples of the
    // fragment size, with full-range values so that every length bit toggles.
    function automatic int pick_length(input int p);
        int len;
        case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = $urandom_range(1, 3);
            2:       len = $urandom_range(1, p);
            3:       len = p;
            4:       len = p + 1;
            5:       len = p * $urandom_range(2, 65535 / p) + $urandom_range(0, 1);
            6:       len = $urandom_range(p + 1, 65535);
            7:       len = 65535;
            default: len = $urandom_range(0, 65535);
        endcase
        if (len > 65535)
            len = 65535;
        return len;
    endfunction

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: single packets, fragment boundaries, empty NALs, longest NAL.
        send_nal(8'h65, 1);
        send_nal(8'h41, 0);
        send_nal(8'h00, 2);
        send_nal(8'hFF, 1400);
        send_nal(8'h7C, 1401);
        send_nal(8'h1F, 2800);
        send_nal(8'h80, 2801);
        send_nal(8'hE5, 65535);
        send_nal(8'h67, 0);

        // Smallest fragment size gives the most fragments per NAL.
        configure(hrf_pkg::PAYLOAD_FLOOR, 17'd90000, 7'd127, 32'hFFFF_FFFF, 1'b1);
        send_nal(8'h25, 1100);
        send_nal(8'h45, 1101);
        send_nal(8'h65, 65535);
        send_nal(8'hA6, 2200);
        send_nal(8'h06, 1);

        // Fragment size register below and above its legal range.
        configure(11'd0, 17'd1, 7'd0, 32'd0, 1'b0);
        send_nal(8'h41, 1100);
        send_nal(8'h41, 1101);
        configure(11'd2047, 17'd131071, 7'h55, 32'hA5A5_5A5A, 1'b0);
        send_nal(8'hFF, 1400);
        send_nal(8'hFF, 1401);
        send_nal(8'h00, 0);

        repeat (5) begin
            configure_random();
            repeat (RANDOM_NALS) begin
                if ($urandom_range(0, 19) == 0)
                    drain();
                send_nal(8'($urandom_range(0, 255)), pick_length(frag_size));
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && descriptors_due == 0)
            $display("tb_h264_rtp_fua_packetizer_top: done, clean");
        else
            $display("tb_h264_rtp_fua_packetizer_top: done, errors");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/hrf_pkg.sv
design/hrf_cfg_regs.sv
design/hrf_frag_unit.sv
design/h264_rtp_fua_packetizer_top.sv
bench/fua_descriptor_checker.sv
bench/tb_h264_rtp_fua_packetizer_top.sv
